// ===== src/drap_pkg.sv =====
`default_nettype none

package drap_pkg;

    typedef enum logic [3:0] {
        PH_HDR    = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QTC    = 4'd2,
        PH_ASTART = 4'd3,
        PH_APTR   = 4'd4,
        PH_ANAME  = 4'd5,
        PH_ATC    = 4'd6,
        PH_TTL    = 4'd7,
        PH_RDLEN  = 4'd8,
        PH_SKIP   = 4'd9,
        PH_ADDR   = 4'd10,
        PH_ERR    = 4'd11
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_ID        = 3'd2;
    localparam logic [2:0] ST_NOTRESP   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_TYPECLASS = 3'd5;

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0]  PTR_BYTE  = 8'hC0;
    localparam logic [15:0] ADDR_LEN  = 16'h0004;
    localparam logic [15:0] TYPE_A    = 16'h0001;
    localparam logic [15:0] CLASS_IN  = 16'h0001;
    localparam logic [15:0] TTL_BYTES = 16'd4;

    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = 2;
    localparam int EVQ_CNT_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [2:0]  status;
        logic        end_of_run;
    } t_out_item;

    typedef struct packed {
        logic        has_addr;
        logic [31:0] address;
        logic        has_status;
        logic [2:0]  status;
    } t_event;

endpackage

`default_nettype wire

// ===== src/drap_parser.sv =====
`default_nettype none

module drap_parser #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wen,
    input  wire [15:0]           i_cfg_wdata,
    input  wire                  i_take,
    input  drap_pkg::t_in_item   i_item,
    output logic                 o_ev_valid,
    output drap_pkg::t_event     o_ev
);

    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

    logic [15:0]         r_expected_id;
    drap_pkg::t_phase    r_phase, n_phase, tk_phase;
    logic [CNT_W-1:0]    r_count, n_count, tk_count;
    logic [15:0]         r_skip, n_skip, tk_skip;
    logic [15:0]         r_qtype, n_qtype, tk_qtype;
    logic [15:0]         r_qclass, n_qclass, tk_qclass;
    logic [15:0]         r_atype, n_atype, tk_atype;
    logic [15:0]         r_aclass, n_aclass, tk_aclass;
    logic [31:0]         r_gather, n_gather, tk_gather;
    logic [2:0]          r_err, n_err, tk_err;
    logic                kept;
    logic [7:0]          b;
    logic [15:0]         len;

    assign b    = i_item.data_byte;
    assign kept = r_count < CNT_W'(MAX_PACKET_BYTES);

    always_comb begin
        tk_phase  = r_phase;
        tk_count  = r_count;
        tk_skip   = r_skip;
        tk_qtype  = r_qtype;
        tk_qclass = r_qclass;
        tk_atype  = r_atype;
        tk_aclass = r_aclass;
        tk_gather = r_gather;
        tk_err    = r_err;
        len       = '0;
        if (kept) begin
            tk_count = r_count + CNT_W'(1);
            unique case (r_phase)
                drap_pkg::PH_HDR: begin
                    if (r_count == CNT_W'(0) && b != r_expected_id[15:8]) begin
                        tk_err   = drap_pkg::ST_ID;
                        tk_phase = drap_pkg::PH_ERR;
                    end else if (r_count == CNT_W'(1) && b != r_expected_id[7:0]) begin
                        tk_err   = drap_pkg::ST_ID;
                        tk_phase = drap_pkg::PH_ERR;
                    end else if (r_count == CNT_W'(2) && !b[7]) begin
                        tk_err   = drap_pkg::ST_NOTRESP;
                        tk_phase = drap_pkg::PH_ERR;
                    end else if (r_count >= CNT_W'(11)) begin
                        tk_phase = drap_pkg::PH_QNAME;
                    end
                end
                drap_pkg::PH_QNAME: begin
                    if (b == 8'd0) begin
                        tk_phase = drap_pkg::PH_QTC;
                        tk_skip  = '0;
                    end
                end
                drap_pkg::PH_QTC: begin
                    if (r_skip < 16'd2) begin
                        tk_qtype = {r_qtype[7:0], b};
                    end else begin
                        tk_qclass = {r_qclass[7:0], b};
                    end
                    tk_skip = r_skip + 16'd1;
                    if (tk_skip >= 16'd4) begin
                        tk_phase = drap_pkg::PH_ASTART;
                        tk_skip  = '0;
                    end
                end
                drap_pkg::PH_ASTART: begin
                    if (b == drap_pkg::PTR_BYTE) begin
                        tk_phase = drap_pkg::PH_APTR;
                    end else if (b == 8'd0) begin
                        tk_phase = drap_pkg::PH_ATC;
                        tk_skip  = '0;
                    end else begin
                        tk_phase = drap_pkg::PH_ANAME;
                    end
                end
                drap_pkg::PH_APTR: begin
                    tk_phase = drap_pkg::PH_ATC;
                    tk_skip  = '0;
                end
                drap_pkg::PH_ANAME: begin
                    if (b == 8'd0) begin
                        tk_phase = drap_pkg::PH_ATC;
                        tk_skip  = '0;
                    end
                end
                drap_pkg::PH_ATC: begin
                    if (r_skip < 16'd2) begin
                        tk_atype = {r_atype[7:0], b};
                    end else begin
                        tk_aclass = {r_aclass[7:0], b};
                    end
                    tk_skip = r_skip + 16'd1;
                    if (tk_skip >= 16'd4) begin
                        if (tk_atype != r_qtype || tk_aclass != r_qclass) begin
                            tk_err   = drap_pkg::ST_TYPECLASS;
                            tk_phase = drap_pkg::PH_ERR;
                        end else begin
                            tk_phase = drap_pkg::PH_TTL;
                            tk_skip  = drap_pkg::TTL_BYTES;
                        end
                    end
                end
                drap_pkg::PH_TTL: begin
                    if (r_skip != 16'd0) begin
                        tk_skip = r_skip - 16'd1;
                    end
                    if (tk_skip == 16'd0) begin
                        tk_phase  = drap_pkg::PH_RDLEN;
                        tk_gather = '0;
                    end
                end
                drap_pkg::PH_RDLEN: begin
                    tk_gather = {r_gather[23:0], b};
                    tk_skip   = r_skip + 16'd1;
                    if (tk_skip >= 16'd2) begin
                        len       = tk_gather[15:0];
                        tk_gather = '0;
                        if (len == drap_pkg::ADDR_LEN) begin
                            tk_phase = drap_pkg::PH_ADDR;
                            tk_skip  = '0;
                        end else if (len == 16'd0) begin
                            tk_phase = drap_pkg::PH_ASTART;
                            tk_skip  = '0;
                        end else begin
                            tk_phase = drap_pkg::PH_SKIP;
                            tk_skip  = len;
                        end
                    end
                end
                drap_pkg::PH_SKIP: begin
                    if (r_skip != 16'd0) begin
                        tk_skip = r_skip - 16'd1;
                    end
                    if (tk_skip == 16'd0) begin
                        tk_phase = drap_pkg::PH_ASTART;
                    end
                end
                drap_pkg::PH_ADDR: begin
                    tk_gather = {r_gather[23:0], b};
                    tk_skip   = r_skip + 16'd1;
                    if (tk_skip >= 16'd4) begin
                        tk_phase = drap_pkg::PH_ASTART;
                        tk_skip  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_skip   = r_skip;
        n_qtype  = r_qtype;
        n_qclass = r_qclass;
        n_atype  = r_atype;
        n_aclass = r_aclass;
        n_gather = r_gather;
        n_err    = r_err;
        if (i_take) begin
            if (i_item.last) begin
                n_phase  = drap_pkg::PH_HDR;
                n_count  = '0;
                n_skip   = '0;
                n_qtype  = '0;
                n_qclass = '0;
                n_atype  = '0;
                n_aclass = '0;
                n_gather = '0;
                n_err    = drap_pkg::ST_OK;
            end else begin
                n_phase  = tk_phase;
                n_count  = tk_count;
                n_skip   = tk_skip;
                n_qtype  = tk_qtype;
                n_qclass = tk_qclass;
                n_atype  = tk_atype;
                n_aclass = tk_aclass;
                n_gather = tk_gather;
                n_err    = tk_err;
            end
        end
    end

    always_comb begin
        o_ev.has_addr   = kept && r_phase == drap_pkg::PH_ADDR
                          && tk_phase == drap_pkg::PH_ASTART
                          && r_atype == drap_pkg::TYPE_A && r_aclass == drap_pkg::CLASS_IN;
        o_ev.address    = tk_gather;
        o_ev.has_status = i_item.last;
        if (tk_count <= CNT_W'(12)) begin
            o_ev.status = drap_pkg::ST_SHORT;
        end else if (tk_err != drap_pkg::ST_OK) begin
            o_ev.status = tk_err;
        end else if (tk_phase == drap_pkg::PH_ASTART) begin
            o_ev.status = drap_pkg::ST_OK;
        end else begin
            o_ev.status = drap_pkg::ST_TRUNC;
        end
        o_ev_valid = i_take && (o_ev.has_addr || o_ev.has_status);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= '0;
            r_phase       <= drap_pkg::PH_HDR;
            r_count       <= '0;
            r_skip        <= '0;
            r_qtype       <= '0;
            r_qclass      <= '0;
            r_atype       <= '0;
            r_aclass      <= '0;
            r_gather      <= '0;
            r_err         <= drap_pkg::ST_OK;
        end else begin
            if (i_cfg_wen) begin
                r_expected_id <= i_cfg_wdata;
            end
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_skip   <= n_skip;
            r_qtype  <= n_qtype;
            r_qclass <= n_qclass;
            r_atype  <= n_atype;
            r_aclass <= n_aclass;
            r_gather <= n_gather;
            r_err    <= n_err;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_item.last |=> r_phase == drap_pkg::PH_HDR && r_count == '0)
        else $error("packet state not cleared after last item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PACKET_BYTES))
        else $error("byte count beyond maximum packet size");

endmodule

`default_nettype wire

// ===== src/drap_evq.sv =====
`default_nettype none

module drap_evq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_wr_en,
    input  drap_pkg::t_event    i_wr_data,
    output logic                o_full,
    input  wire                 i_rd_en,
    output drap_pkg::t_event    o_rd_data,
    output logic                o_empty
);

    drap_pkg::t_event                 r_mem [drap_pkg::EVQ_DEPTH];
    logic [drap_pkg::EVQ_PTR_W-1:0]   r_wptr, r_rptr;
    logic [drap_pkg::EVQ_CNT_W-1:0]   r_count;
    logic                             do_wr, do_rd;

    assign o_full    = r_count == drap_pkg::EVQ_CNT_W'(drap_pkg::EVQ_DEPTH);
    assign o_empty   = r_count == '0;
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= r_wptr + drap_pkg::EVQ_PTR_W'(1);
            end
            if (do_rd) begin
                r_rptr <= r_rptr + drap_pkg::EVQ_PTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + drap_pkg::EVQ_CNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - drap_pkg::EVQ_CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> !o_full)
        else $error("event written into a full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= drap_pkg::EVQ_CNT_W'(drap_pkg::EVQ_DEPTH))
        else $error("event queue count out of range");

endmodule

`default_nettype wire

// ===== src/drap_emit.sv =====
`default_nettype none

module drap_emit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  drap_pkg::t_event     i_head,
    input  wire                  i_head_empty,
    output logic                 o_head_pop,
    output logic                 o_empty,
    input  wire                  i_pop,
    output drap_pkg::t_out_item  o_item
);

    logic r_second, n_second;
    logic show_addr;
    logic taken;

    assign o_empty   = i_head_empty;
    assign show_addr = i_head.has_addr && !r_second;
    assign taken     = i_pop && !i_head_empty;

    always_comb begin
        o_item.kind       = show_addr ? drap_pkg::KIND_ADDR : drap_pkg::KIND_STATUS;
        o_item.address    = show_addr ? i_head.address : 32'd0;
        o_item.status     = show_addr ? drap_pkg::ST_OK : i_head.status;
        o_item.end_of_run = !show_addr;
    end

    always_comb begin
        n_second   = r_second;
        o_head_pop = 1'b0;
        if (taken) begin
            if (show_addr && i_head.has_status) begin
                n_second = 1'b1;
            end else begin
                n_second   = 1'b0;
                o_head_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !i_head_empty && i_head.has_addr && i_head.has_status)
        else $error("status half pending without a two-result event");

endmodule

`default_nettype wire

// ===== src/dns_response_address_parser_core.sv =====
`default_nettype none

// Accepts one packet byte per cycle while full is low; a byte never waits on the result side
// until the four-entry event queue fills.
// A result is registered in the event queue as its byte is accepted, behind any older events.
// A byte may cause an address item and a status item; they leave one per pop, in that order.
// Synchronous active-low reset clears the parse state, the queue and the expected ID to zero.
module dns_response_address_parser_core #(
    parameter int MAX_PACKET_BYTES = 512
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wen,
    input  wire [15:0]           i_cfg_wdata,
    input  wire                  push,
    input  drap_pkg::t_in_item   i_item,
    output logic                 full,
    output logic                 empty,
    input  wire                  pop,
    output drap_pkg::t_out_item  o_item
);

    logic             take;
    logic             ev_valid;
    drap_pkg::t_event ev;
    drap_pkg::t_event head;
    logic             head_empty;
    logic             head_pop;

    assign take = push && !full;

    drap_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_take     (take),
        .i_item     (i_item),
        .o_ev_valid (ev_valid),
        .o_ev       (ev)
    );

    drap_evq u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (ev_valid),
        .i_wr_data(ev),
        .o_full   (full),
        .i_rd_en  (head_pop),
        .o_rd_data(head),
        .o_empty  (head_empty)
    );

    drap_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_head_empty(head_empty),
        .o_head_pop  (head_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

`default_nettype wire
